FILE: design/ptl_pkg.sv
// Shared types, codes and constants of the pulse train learner.
// Has no dependencies; every other file of the block imports it.
package ptl_pkg;

  // Default sizes of the width table and of the pulse sequence.
  localparam int unsigned WidthSlotsDef = 16;
  localparam int unsigned SeqDepthDef   = 256;

  // Fixed field widths.
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned PW_W      = 16;
  localparam int unsigned TS_W      = 32;
  localparam int unsigned FLEN_W    = 9;
  localparam int unsigned DWID_W    = 5;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned APB_DW    = 32;

  // Item modes.
  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_SAMPLE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LEARNED = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_MIN_PULSE = 3'd0;
  localparam logic [2:0] REG_MIN_GAP   = 3'd1;
  localparam logic [2:0] REG_TOL       = 3'd2;
  localparam logic [2:0] REG_MIN_FRAME = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;

  // Register reset values.
  localparam logic [15:0] RST_MIN_PULSE = 16'd70;
  localparam logic [15:0] RST_MIN_GAP   = 16'd3000;
  localparam logic [15:0] RST_TOL       = 16'd100;
  localparam logic [8:0]  RST_MIN_FRAME = 9'd20;
  localparam logic [31:0] RST_TIMEOUT   = 32'd10000000;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [15:0] min_pulse;
    logic [15:0] min_gap;
    logic [15:0] match_tol;
    logic [8:0]  min_frame;
    logic [31:0] timeout;
  } cfg_t;

  // Search word that walks along the width cells.
  typedef struct packed {
    logic              vld;
    logic [PW_W-1:0]   width;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } tok_t;

endpackage

FILE: design/ptl_cfg_regs.sv
// APB-style configuration registers of the pulse train learner.
// Depends on ptl_pkg for the register indexes, reset values and cfg_t.
module ptl_cfg_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptl_pkg::APB_AW-1:0] paddr,
  input  logic [ptl_pkg::APB_DW-1:0] pwdata,
  output logic [ptl_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ptl_pkg::cfg_t              cfg_o
);
  import ptl_pkg::*;

  cfg_t        cfg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  // Register writes; addresses past the last register are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse <= RST_MIN_PULSE;
      cfg_q.min_gap   <= RST_MIN_GAP;
      cfg_q.match_tol <= RST_TOL;
      cfg_q.min_frame <= RST_MIN_FRAME;
      cfg_q.timeout   <= RST_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_PULSE: cfg_q.min_pulse <= pwdata[15:0];
        REG_MIN_GAP:   cfg_q.min_gap   <= pwdata[15:0];
        REG_TOL:       cfg_q.match_tol <= pwdata[15:0];
        REG_MIN_FRAME: cfg_q.min_frame <= pwdata[8:0];
        REG_TIMEOUT:   cfg_q.timeout   <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_MIN_PULSE: prdata = {16'd0, cfg_q.min_pulse};
      REG_MIN_GAP:   prdata = {16'd0, cfg_q.min_gap};
      REG_TOL:       prdata = {16'd0, cfg_q.match_tol};
      REG_MIN_FRAME: prdata = {23'd0, cfg_q.min_frame};
      REG_TIMEOUT:   prdata = cfg_q.timeout;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: design/ptl_cell.sv
// One width cell: holds one stored pulse width and checks the passing search word.
// Depends on ptl_pkg for tok_t and the field widths.
module ptl_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ptl_pkg::SLOT_W-1:0] cell_idx_i,
  input  logic                       live_i,
  input  logic [ptl_pkg::PW_W-1:0]   tol_i,
  input  logic                       wr_en_i,
  input  logic [ptl_pkg::PW_W-1:0]   wr_width_i,
  input  ptl_pkg::tok_t              tok_i,
  output ptl_pkg::tok_t              tok_o,
  output logic [ptl_pkg::PW_W-1:0]   width_o
);
  import ptl_pkg::*;

  logic [PW_W-1:0] width_q;
  logic [PW_W-1:0] diff;
  tok_t            tok_d;
  tok_t            tok_q;

  assign width_o = width_q;
  assign tok_o   = tok_q;

  // Absolute difference to the searched width.
  assign diff = (width_q >= tok_i.width) ? (width_q - tok_i.width)
                                         : (tok_i.width - width_q);

  // The first live cell within tolerance claims the word.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && live_i && !tok_i.found && (diff <= tol_i)) begin
      tok_d.found = 1'b1;
      tok_d.slot  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  // Stored width, written by the sequencer.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      width_q <= wr_width_i;
    end
  end

endmodule

FILE: design/ptl_width_chain.sv
// Row of width cells that the search word walks through, one cell a cycle.
// Depends on ptl_pkg and ptl_cell.
module ptl_width_chain #(
  parameter int unsigned WIDTH_SLOTS = ptl_pkg::WidthSlotsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [$clog2(WIDTH_SLOTS+1)-1:0]     count_i,
  input  logic [ptl_pkg::PW_W-1:0]             tol_i,
  input  ptl_pkg::tok_t                        tok_i,
  input  logic [WIDTH_SLOTS-1:0]               wr_en_i,
  input  logic [ptl_pkg::PW_W-1:0]             wr_width_i,
  input  logic [$clog2(WIDTH_SLOTS)-1:0]       rd_slot_i,
  output ptl_pkg::tok_t                        tok_o,
  output logic [ptl_pkg::PW_W-1:0]             rd_width_o
);
  import ptl_pkg::*;

  tok_t            chain_tok  [WIDTH_SLOTS+1];
  logic [PW_W-1:0] cell_width [WIDTH_SLOTS];

  assign chain_tok[0] = tok_i;
  assign tok_o        = chain_tok[WIDTH_SLOTS];
  assign rd_width_o   = cell_width[rd_slot_i];

  // A cell is live when its index is below the current table fill.
  for (genvar k = 0; k < WIDTH_SLOTS; k++) begin : g_cell
    ptl_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (SLOT_W'(k)),
      .live_i     (32'(count_i) > k),
      .tol_i      (tol_i),
      .wr_en_i    (wr_en_i[k]),
      .wr_width_i (wr_width_i),
      .tok_i      (chain_tok[k]),
      .tok_o      (chain_tok[k+1]),
      .width_o    (cell_width[k])
    );
  end

endmodule

FILE: design/pulse_train_learner_core.sv
// Top level of the pulse train learner: item sequencer, pulse sequence memory.
// Depends on ptl_pkg, ptl_cfg_regs, ptl_width_chain and ptl_cell.
//
//   Port group  Direction  Handshake              Contents
//   input word  in         in_valid_i/in_stall_o  mode, timestamp_us, line_level, pulse_index
//   result word out        out_valid_o/out_stall_i status, frame_length, distinct_widths,
//                                                 pulse_width
//   config      APB        psel/penable/pwrite    five registers at byte address 4*i
//
// One word at a time. Each word passes evaluate and done; reads also the read state. Idle
// samples go straight to done; others go via check on a timeout or an unchanged level, via
// check and frame on a level change too short to be a pulse, and via check, scan and frame
// when they record a pulse: the search word walks the width cells one per cycle. The output
// register lets the next word be taken while a result waits. Reset is asynchronous and
// clears all control state; no clearing pass is needed. A stalled result holds.
module pulse_train_learner_core #(
  parameter int unsigned WIDTH_SLOTS    = ptl_pkg::WidthSlotsDef,
  parameter int unsigned SEQUENCE_DEPTH = ptl_pkg::SeqDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 mode_i,
  input  logic [31:0]                timestamp_us_i,
  input  logic                       line_level_i,
  input  logic [7:0]                 pulse_index_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [8:0]                 frame_length_o,
  output logic [4:0]                 distinct_widths_o,
  output logic [15:0]                pulse_width_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ptl_pkg::APB_AW-1:0] paddr,
  input  logic [ptl_pkg::APB_DW-1:0] pwdata,
  output logic [ptl_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import ptl_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WIDTH_SLOTS + 1);
  localparam int unsigned SIDX_W = $clog2(WIDTH_SLOTS);
  localparam int unsigned LEN_W  = $clog2(SEQUENCE_DEPTH + 1);
  localparam int unsigned SEQ_AW = $clog2(SEQUENCE_DEPTH);
  localparam int unsigned CMP_W  = (LEN_W > FLEN_W) ? LEN_W : FLEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_CHECK, S_SCAN, S_FRAME, S_READ, S_DONE
  } state_e;

  cfg_t cfg;

  state_e             state_q;
  logic [1:0]         mode_q;
  logic [TS_W-1:0]    now_q;
  logic               level_q;
  logic [7:0]         idx_q;
  logic               active_q;
  logic [TS_W-1:0]    start_q;
  logic [TS_W-1:0]    edge_q;
  logic               plevel_q;
  logic [LEN_W-1:0]   prev_len_q;
  logic [PW_W-1:0]    prev_gap_q;
  logic [CNT_W-1:0]   count_q;
  logic [LEN_W-1:0]   len_q;
  logic [TS_W-1:0]    el_q;
  logic [PW_W-1:0]    w_q;
  logic [1:0]         status_q;
  logic [PW_W-1:0]    wout_q;
  logic               out_valid_q;
  logic [1:0]         out_status_q;
  logic [FLEN_W-1:0]  out_len_q;
  logic [DWID_W-1:0]  out_cnt_q;
  logic [PW_W-1:0]    out_width_q;

  // Pulse sequence memory.
  logic [SLOT_W-1:0]  seq_mem [SEQUENCE_DEPTH];
  logic [SLOT_W-1:0]  seq_rd_q;
  logic               seq_we;
  logic [SEQ_AW-1:0]  seq_waddr;
  logic [SLOT_W-1:0]  seq_wdata;

  tok_t                   tok_launch;
  tok_t                   tok_tail;
  logic [WIDTH_SLOTS-1:0] cell_we;
  logic [PW_W-1:0]        rd_width;

  logic               in_acc;
  logic               out_free;
  logic               borrow_s;
  logic               borrow_e;
  logic [TS_W-1:0]    el_start;
  logic [TS_W-1:0]    el_edge;
  logic               timed_out;
  logic               lvl_change;
  logic               is_pulse;
  logic               scan_done;
  logic               add_new;
  logic               app_fail;
  logic [SLOT_W-1:0]  app_slot;
  logic               frame_end;
  logic [PW_W-1:0]    gap_diff;
  logic               gap_match;
  logic               idx_ok;
  logic               slot_ok;

  assign in_stall_o        = (state_q != S_IDLE);
  assign in_acc            = in_valid_i && !in_stall_o;
  assign out_free          = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign frame_length_o    = out_len_q;
  assign distinct_widths_o = out_cnt_q;
  assign pulse_width_o     = out_width_q;

  ptl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Elapsed time with the wrap rule: now - then, less one when the counter wrapped.
  assign borrow_s = now_q < start_q;
  assign borrow_e = now_q < edge_q;
  assign el_start = now_q + ~start_q + TS_W'(!borrow_s);
  assign el_edge  = now_q + ~edge_q + TS_W'(!borrow_e);

  // Decisions taken in the check step.
  assign timed_out  = el_q > cfg.timeout;
  assign lvl_change = level_q != plevel_q;
  assign is_pulse   = w_q >= cfg.min_pulse;

  always_comb begin
    tok_launch       = '0;
    tok_launch.vld   = (state_q == S_CHECK) && !timed_out && lvl_change && is_pulse;
    tok_launch.width = w_q;
  end

  ptl_width_chain #(
    .WIDTH_SLOTS (WIDTH_SLOTS)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .count_i    (count_q),
    .tol_i      (cfg.match_tol),
    .tok_i      (tok_launch),
    .wr_en_i    (cell_we),
    .wr_width_i (w_q),
    .rd_slot_i  (seq_rd_q[SIDX_W-1:0]),
    .tok_o      (tok_tail),
    .rd_width_o (rd_width)
  );

  // Append: reuse the matched slot, else take a new one; a full table or
  // sequence restarts the capture with this pulse alone.
  assign scan_done = (state_q == S_SCAN) && tok_tail.vld;
  assign add_new   = !tok_tail.found && (32'(count_q) < WIDTH_SLOTS);
  assign app_slot  = tok_tail.found ? tok_tail.slot : SLOT_W'(count_q);
  assign app_fail  = (!tok_tail.found && !add_new) || (32'(len_q) >= SEQUENCE_DEPTH);

  always_comb begin
    for (int k = 0; k < WIDTH_SLOTS; k++) begin
      cell_we[k] = scan_done && ((add_new && (32'(count_q) == k)) || (app_fail && (k == 0)));
    end
  end

  assign seq_we    = scan_done;
  assign seq_waddr = app_fail ? '0 : len_q[SEQ_AW-1:0];
  assign seq_wdata = app_fail ? '0 : app_slot;

  always_ff @(posedge clk_i) begin
    if (seq_we) begin
      seq_mem[seq_waddr] <= seq_wdata;
    end
    seq_rd_q <= seq_mem[SEQ_AW'(idx_q)];
  end

  // Frame end and the comparison with the previous frame.
  assign frame_end = (CMP_W'(len_q) >= CMP_W'(cfg.min_frame)) && (w_q > cfg.min_gap);
  assign gap_diff  = (prev_gap_q >= w_q) ? (prev_gap_q - w_q) : (w_q - prev_gap_q);
  assign gap_match = gap_diff <= cfg.match_tol;

  // Read item checks.
  assign idx_ok  = 32'(idx_q) < SEQUENCE_DEPTH;
  assign slot_ok = 32'(seq_rd_q) < WIDTH_SLOTS;

  // Item sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      mode_q       <= MODE_START;
      now_q        <= '0;
      level_q      <= 1'b0;
      idx_q        <= '0;
      active_q     <= 1'b0;
      start_q      <= '0;
      edge_q       <= '0;
      plevel_q     <= 1'b0;
      prev_len_q   <= '0;
      prev_gap_q   <= '0;
      count_q      <= '0;
      len_q        <= '0;
      el_q         <= '0;
      w_q          <= '0;
      status_q     <= ST_IDLE;
      wout_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_len_q    <= '0;
      out_cnt_q    <= '0;
      out_width_q  <= '0;
    end else begin
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= status_q;
        out_len_q    <= FLEN_W'(len_q);
        out_cnt_q    <= DWID_W'(count_q);
        out_width_q  <= wout_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            mode_q   <= mode_i;
            now_q    <= timestamp_us_i;
            level_q  <= line_level_i;
            idx_q    <= pulse_index_i;
            wout_q   <= '0;
            status_q <= active_q ? ST_OK : ST_IDLE;
            state_q  <= S_EVAL;
          end
        end
        S_EVAL: begin
          unique case (mode_q)
            MODE_START: begin
              count_q    <= '0;
              len_q      <= '0;
              prev_len_q <= '0;
              start_q    <= now_q;
              edge_q     <= now_q;
              plevel_q   <= level_q;
              active_q   <= 1'b1;
              status_q   <= ST_OK;
              state_q    <= S_DONE;
            end
            MODE_SAMPLE: begin
              el_q    <= el_start;
              w_q     <= el_edge[PW_W-1:0];
              state_q <= active_q ? S_CHECK : S_DONE;
            end
            MODE_READ: begin
              state_q <= S_READ;
            end
            MODE_NONE: begin
              state_q <= S_DONE;
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_CHECK: begin
          if (timed_out) begin
            active_q <= 1'b0;
            status_q <= ST_TIMEOUT;
            state_q  <= S_DONE;
          end else if (lvl_change) begin
            plevel_q <= level_q;
            edge_q   <= now_q;
            state_q  <= is_pulse ? S_SCAN : S_FRAME;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SCAN: begin
          if (tok_tail.vld) begin
            if (app_fail) begin
              count_q <= CNT_W'(1);
              len_q   <= LEN_W'(1);
            end else begin
              if (add_new) begin
                count_q <= count_q + CNT_W'(1);
              end
              len_q <= len_q + LEN_W'(1);
            end
            state_q <= S_FRAME;
          end
        end
        S_FRAME: begin
          if (frame_end) begin
            if ((prev_len_q == len_q) && gap_match) begin
              active_q <= 1'b0;
              status_q <= ST_LEARNED;
            end else begin
              prev_len_q <= len_q;
              prev_gap_q <= w_q;
              count_q    <= '0;
              len_q      <= '0;
            end
          end
          state_q <= S_DONE;
        end
        S_READ: begin
          wout_q  <= (idx_ok && slot_ok) ? rd_width : '0;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the cell row.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input word taken while a word was still in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= WIDTH_SLOTS)
    else $error("width table fill beyond its size");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(len_q) <= SEQUENCE_DEPTH)
    else $error("pulse sequence fill beyond its depth");

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_tail.vld |-> (state_q == S_SCAN))
    else $error("search word left the cell row outside the scan step");

endmodule

FILE: bench/tb_pulse_train_learner_core.sv
// Self-checking testbench for pulse_train_learner_core: a directed table, then random pulse trains.
// Depends on ptl_pkg and the core; each word's result is checked against the table's value or a model of the learner.
module tb_pulse_train_learner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ptl_pkg::*;

  localparam int unsigned WIDTH_SLOTS    = WidthSlotsDef;
  localparam int unsigned SEQUENCE_DEPTH = SeqDepthDef;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = WIDTH_SLOTS + 8;
  localparam int unsigned DIR_ROWS       = 24;
  localparam int unsigned PHASES         = 6;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ts;
    logic        lvl;
    logic [7:0]  idx;
  } line_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  flen;
    logic [4:0]  nwid;
    logic [15:0] width;
  } learner_out_t;

  typedef struct packed {
    line_word_t   w;
    logic         typed;
    learner_out_t want;
  } step_row_t;

  // Block ports; every input is known from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = MODE_NONE;
  logic [31:0] timestamp_us_i = '0;
  logic        line_level_i = 1'b0;
  logic [7:0]  pulse_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [8:0]  frame_length_o;
  logic [4:0]  distinct_widths_o;
  logic [15:0] pulse_width_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  pulse_train_learner_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .timestamp_us_i   (timestamp_us_i),
    .line_level_i     (line_level_i),
    .pulse_index_i    (pulse_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .frame_length_o   (frame_length_o),
    .distinct_widths_o(distinct_widths_o),
    .pulse_width_o    (pulse_width_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Learner model: configuration and capture state.
  logic [15:0]  c_min_pulse, c_min_gap, c_tol;
  logic [8:0]   c_min_frame;
  logic [31:0]  c_timeout;
  logic [15:0]  wtab [WIDTH_SLOTS];
  logic [3:0]   pseq [SEQUENCE_DEPTH];
  int unsigned  wcnt, slen, prev_flen;
  logic [15:0]  prev_gap;
  logic         prev_lvl;
  logic [31:0]  prev_edge, cap_start;
  bit           active;
  // One past the highest sequence position ever written; reads stay below it.
  int unsigned  seq_high;

  learner_out_t awaited_reports [$];
  int unsigned  fault_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  fed_items;
  logic [31:0]  last_ts = '0;
  bit           idling_on = 1'b1;
  int unsigned  calm_tx = 0;
  int unsigned  calm_rx = 0;
  int unsigned  stall_left = 0;

  step_row_t directed_rows [DIR_ROWS] = '{
    // Idle block: samples and unused words report idle.
    '{'{MODE_SAMPLE, 32'd0, 1'b1, 8'h00}, 1'b1, '{ST_IDLE, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_NONE, 32'hFFFF_FFFF, 1'b1, 8'hFF}, 1'b1, '{ST_IDLE, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_START, 32'd0, 1'b0, 8'hAA}, 1'b1, '{ST_OK, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_NONE, 32'd0, 1'b0, 8'h55}, 1'b1, '{ST_OK, 9'd0, 5'd0, 16'd0}},
    // A pulse, no level change, a glitch, a width exactly at tolerance, one just past it.
    '{'{MODE_SAMPLE, 32'd100, 1'b1, 8'h00}, 1'b1, '{ST_OK, 9'd1, 5'd1, 16'd0}},
    '{'{MODE_SAMPLE, 32'd120, 1'b1, 8'h00}, 1'b1, '{ST_OK, 9'd1, 5'd1, 16'd0}},
    '{'{MODE_SAMPLE, 32'd169, 1'b0, 8'h00}, 1'b1, '{ST_OK, 9'd1, 5'd1, 16'd0}},
    '{'{MODE_SAMPLE, 32'd369, 1'b1, 8'h00}, 1'b1, '{ST_OK, 9'd2, 5'd1, 16'd0}},
    '{'{MODE_SAMPLE, 32'd570, 1'b0, 8'h00}, 1'b1, '{ST_OK, 9'd3, 5'd2, 16'd0}},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd0}, 1'b1, '{ST_OK, 9'd3, 5'd2, 16'd100}},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd1}, 1'b1, '{ST_OK, 9'd3, 5'd2, 16'd100}},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd2}, 1'b1, '{ST_OK, 9'd3, 5'd2, 16'd201}},
    // Timeout, then idle samples and reads.
    '{'{MODE_SAMPLE, 32'h00FF_FFFF, 1'b1, 8'h00}, 1'b1, '{ST_TIMEOUT, 9'd3, 5'd2, 16'd0}},
    '{'{MODE_SAMPLE, 32'h0100_0000, 1'b0, 8'h00}, 1'b1, '{ST_IDLE, 9'd3, 5'd2, 16'd0}},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd2}, 1'b1, '{ST_IDLE, 9'd3, 5'd2, 16'd201}},
    // Pulse across the timestamp wrap.
    '{'{MODE_START, 32'hFFFF_FFF0, 1'b1, 8'h00}, 1'b1, '{ST_OK, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_SAMPLE, 32'h0000_0050, 1'b0, 8'h00}, 1'b0, '0},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd0}, 1'b0, '0},
    // A timestamp just behind the start time wraps into a timeout.
    '{'{MODE_START, 32'd5, 1'b0, 8'h00}, 1'b1, '{ST_OK, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_SAMPLE, 32'd4, 1'b1, 8'h00}, 1'b1, '{ST_TIMEOUT, 9'd0, 5'd0, 16'd0}},
    // Width keeps only its low 16 bits; a long interval below the frame count.
    '{'{MODE_START, 32'd1000, 1'b1, 8'h00}, 1'b1, '{ST_OK, 9'd0, 5'd0, 16'd0}},
    '{'{MODE_SAMPLE, 32'd66616, 1'b0, 8'h00}, 1'b0, '0},
    '{'{MODE_READ, 32'd0, 1'b0, 8'd0}, 1'b0, '0},
    '{'{MODE_SAMPLE, 32'd70116, 1'b1, 8'h00}, 1'b0, '0}
  };

  // Elapsed microseconds with the one-short wrap rule.
  function automatic logic [31:0] span_us(input logic [31:0] now, input logic [31:0] then_us);
    if (now >= then_us) return now - then_us;
    return 32'hFFFF_FFFF - (then_us - now);
  endfunction

  function automatic bit near(input logic [15:0] a, input logic [15:0] b);
    int unsigned d;
    d = 32'((a > b) ? a - b : b - a);
    return d <= 32'(c_tol);
  endfunction

  // Match the width in the table, add it if new, then append its slot.
  function automatic bit record_pulse(input logic [15:0] pw);
    int unsigned slot;
    slot = WIDTH_SLOTS;
    for (int unsigned k = 0; k < wcnt; k++) begin
      if (near(wtab[k], pw)) begin
        slot = k;
        break;
      end
    end
    if (slot == WIDTH_SLOTS) begin
      if (wcnt >= WIDTH_SLOTS) return 1'b0;
      slot = wcnt;
      wtab[slot] = pw;
      wcnt++;
    end
    if (slen >= SEQUENCE_DEPTH) return 1'b0;
    pseq[slen] = slot[3:0];
    slen++;
    if (slen > seq_high) seq_high = slen;
    return 1'b1;
  endfunction

  function automatic void learner_reset();
    c_min_pulse = RST_MIN_PULSE;
    c_min_gap   = RST_MIN_GAP;
    c_tol       = RST_TOL;
    c_min_frame = RST_MIN_FRAME;
    c_timeout   = RST_TIMEOUT;
    foreach (wtab[k]) wtab[k] = '0;
    foreach (pseq[k]) pseq[k] = '0;
    wcnt = 0;
    slen = 0;
    prev_flen = 0;
    prev_gap = '0;
    prev_lvl = 1'b0;
    prev_edge = '0;
    cap_start = '0;
    active = 1'b0;
    seq_high = 0;
  endfunction

  // Advances the learner by one word and returns the report it gives.
  function automatic learner_out_t learn_step(input line_word_t w);
    learner_out_t r;
    logic [31:0]  dt;
    logic [15:0]  pw;
    r = '0;
    r.status = active ? ST_OK : ST_IDLE;
    case (w.mode)
      MODE_START: begin
        wcnt = 0;
        slen = 0;
        prev_flen = 0;
        cap_start = w.ts;
        prev_edge = w.ts;
        prev_lvl = w.lvl;
        active = 1'b1;
        r.status = ST_OK;
      end
      MODE_SAMPLE: begin
        if (active) begin
          if (span_us(w.ts, cap_start) > c_timeout) begin
            active = 1'b0;
            r.status = ST_TIMEOUT;
          end else if (w.lvl != prev_lvl) begin
            dt = span_us(w.ts, prev_edge);
            pw = dt[15:0];
            if (pw >= c_min_pulse) begin
              // A full table or sequence restarts the capture with this pulse.
              if (!record_pulse(pw)) begin
                wcnt = 0;
                slen = 0;
                void'(record_pulse(pw));
              end
            end
            prev_lvl = w.lvl;
            prev_edge = w.ts;
            if (slen >= c_min_frame && pw > c_min_gap) begin
              if (prev_flen == slen && near(prev_gap, pw)) begin
                active = 1'b0;
                r.status = ST_LEARNED;
              end else begin
                prev_flen = slen;
                prev_gap = pw;
                wcnt = 0;
                slen = 0;
              end
            end
          end
        end
      end
      MODE_READ: r.width = wtab[pseq[w.idx]];
      default: ;
    endcase
    r.flen = slen[8:0];
    r.nwid = wcnt[4:0];
    return r;
  endfunction

  // Offers one word, with an occasional idle burst ahead of it.
  task automatic drive_word(input line_word_t w, input bit typed, input learner_out_t typed_out);
    learner_out_t guess;
    if (idling_on) begin
      if (calm_tx > 0) begin
        calm_tx--;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_tx = $urandom_range(40, 160);
      end else if ($urandom_range(0, 4) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
    in_valid_i     <= 1'b1;
    mode_i         <= w.mode;
    timestamp_us_i <= w.ts;
    line_level_i   <= w.lvl;
    pulse_index_i  <= w.idx;
    do @(posedge clk_i); while (in_stall_o);
    guess = learn_step(w);
    awaited_reports.push_back(typed ? typed_out : guess);
    if (w.mode != MODE_NONE) fed_items++;
    if (w.mode == MODE_START || w.mode == MODE_SAMPLE) last_ts = w.ts;
  endtask

  task automatic send_line(input logic [1:0] mode, input logic [31:0] t, input logic lvl);
    line_word_t w;
    w.mode = mode;
    w.ts   = t;
    w.lvl  = lvl;
    w.idx  = 8'($urandom_range(0, 255));
    if (mode == MODE_READ) w.idx = 8'($urandom_range(0, seq_high - 1));
    drive_word(w, 1'b0, '0);
  endtask

  // Holds the sender back until every report is in.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_reports.size() != 0);
  endtask

  // APB write: setup phase, then access phase; psel stays up for back-to-back writes.
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_MIN_PULSE: c_min_pulse = val[15:0];
      REG_MIN_GAP:   c_min_gap   = val[15:0];
      REG_TOL:       c_tol       = val[15:0];
      REG_MIN_FRAME: c_min_frame = val[8:0];
      REG_TIMEOUT:   c_timeout   = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [31:0] mp, input logic [31:0] mg,
                               input logic [31:0] tol, input logic [31:0] mf,
                               input logic [31:0] to);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    reg_write(REG_MIN_PULSE, mp);
    reg_write(REG_MIN_GAP, mg);
    reg_write(REG_TOL, tol);
    reg_write(REG_MIN_FRAME, mf);
    reg_write(REG_TIMEOUT, to);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // A repeating frame of pulses from a small width palette, closed by a gap.
  // A long run has no gap and is meant to overflow the sequence.
  task automatic run_train(input bit long_run);
    int unsigned palette [20];
    int unsigned shape [272];
    int unsigned k, step, base, n, reps, gap, tol2, width;
    logic [31:0] t;
    logic        lvl;
    bit          drop;
    tol2 = (32'(c_tol) / 2 > 40) ? 40 : 32'(c_tol) / 2;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
    if (long_run) k = $urandom_range(1, 20);
    step = 2 * 32'(c_tol) + 1 + $urandom_range(0, 20);
    base = 32'(c_min_pulse) + $urandom_range(0, 50);
    for (int unsigned i = 0; i < k; i++) palette[i] = base + i * step;
    n = 32'(c_min_frame) + $urandom_range(0, 6);
    if (n > 60) n = 60;
    if (n == 0) n = 1;
    if (long_run) n = $urandom_range(250, 270);
    for (int unsigned i = 0; i < n; i++) shape[i] = $urandom_range(0, k - 1);
    gap = 32'(c_min_gap) + 1 + $urandom_range(0, tol2);
    reps = long_run ? 1 : $urandom_range(2, 4);
    t = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 300000) : $urandom;
    lvl = 1'($urandom_range(0, 1));
    send_line(MODE_START, t, lvl);
    repeat (reps) begin
      for (int unsigned i = 0; i < n + (long_run ? 0 : 1); i++) begin
        width = (i == n) ? gap : palette[shape[i]] + $urandom_range(0, tol2);
        drop = 1'b0;
        // Occasional noise between edges.
        case ($urandom_range(0, 39))
          0: send_line(MODE_SAMPLE, t + width / 2, lvl);
          1: if (seq_high > 0) send_line(MODE_READ, '0, 1'b0);
          2: send_line(MODE_NONE, $urandom, 1'($urandom_range(0, 1)));
          3: drop = 1'b1;
          default: ;
        endcase
        t = t + width;
        if (!drop) lvl = !lvl;
        send_line(MODE_SAMPLE, t, lvl);
        if (!active) return;
      end
    end
  endtask

  // A few loose words: any mode, timestamps near or far from the last one.
  task automatic noise_burst();
    line_word_t w;
    repeat ($urandom_range(1, 8)) begin
      w.mode = 2'($urandom_range(0, 3));
      if (w.mode == MODE_START && $urandom_range(0, 2) != 0) w.mode = MODE_SAMPLE;
      w.ts  = ($urandom_range(0, 7) == 0) ? $urandom : last_ts + $urandom_range(0, 70000);
      w.lvl = 1'($urandom_range(0, 1));
      w.idx = 8'($urandom_range(0, 255));
      if (w.mode == MODE_READ) begin
        if (seq_high == 0) w.mode = MODE_NONE;
        else w.idx = 8'($urandom_range(0, seq_high - 1));
      end
      drive_word(w, 1'b0, '0);
    end
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // Result side: check each accepted word, then pick the stall for the next cycle.
  always @(posedge clk_i) begin
    learner_out_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status = status_o;
      got.flen   = frame_length_o;
      got.nwid   = distinct_widths_o;
      got.width  = pulse_width_o;
      if (awaited_reports.size() == 0) begin
        note_fault($sformatf("unexpected result: status %0d len %0d widths %0d pw %0d",
                             got.status, got.flen, got.nwid, got.width));
      end else begin
        want = awaited_reports.pop_front();
        if (got !== want) begin
          note_fault($sformatf({"result mismatch: expected status %0d len %0d widths %0d ",
                                "pw %0d, got status %0d len %0d widths %0d pw %0d"},
                               want.status, want.flen, want.nwid, want.width,
                               got.status, got.flen, got.nwid, got.width));
        end
      end
    end
    if (!idling_on) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (calm_rx > 0) begin
      calm_rx--;
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall_i <= 1'b1;
    end else begin
      if ($urandom_range(0, 49) == 0) calm_rx = $urandom_range(100, 300);
      out_stall_i <= 1'b0;
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned budget [PHASES];
    int unsigned pick;
    budget = '{350, 150, 200, 400, 300, 350};
    learner_reset();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed table under the reset settings.
    foreach (directed_rows[r]) begin
      drive_word(directed_rows[r].w, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases, each under its own settings; the last one without idling.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_settings(70, 3000, 100, 20, 10000000);
        1: load_settings(0, 0, 0, 0, 0);
        2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 256, 32'hFFFF_FFFF);
        3: load_settings(20, 1500, 10, 4, 200000);
        4: load_settings($urandom_range(0, 400), $urandom_range(500, 5000),
                         $urandom_range(0, 300), $urandom_range(0, 30),
                         $urandom_range(50000, 2000000));
        default: begin
          idling_on = 1'b0;
          load_settings(50, 2000, 40, 8, 1000000);
        end
      endcase
      fed_items = 0;
      while (fed_items < budget[ph]) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) run_train(1'b1);
        else if (pick < 78) run_train(1'b0);
        else if (pick < 97) noise_burst();
        else wait_drain();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_reports.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", awaited_reports.size()));
    end
    if (fault_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
